FILE: rtl/core/tpm_pkg.sv
// tpm_pkg: shared widths, action and register codes, and burst control type
// for the token pair merge replacer; no dependencies
`timescale 1ns / 1ps

package tpm_pkg;

	localparam int CHAR_W      = 21;
	localparam int ACT_W       = 2;
	localparam int IDX_W       = 4;
	localparam int LEN_W       = 4;
	localparam int CFG_IDX_W   = 2;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;

	localparam logic [ACT_W-1:0] ACT_LOAD = 2'd0;
	localparam logic [ACT_W-1:0] ACT_CHAR = 2'd1;
	localparam logic [ACT_W-1:0] ACT_END  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_LEN  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SECOND_LEN = 2'd1;

	localparam logic [CHAR_W-1:0] SPACE_CODE = 21'h20;

	typedef struct packed {
		logic has_char;
		logic word_end;
	} burst_ctl_t;

endpackage

FILE: rtl/core/token_pair_merge_replacer.sv
// token_pair_merge_replacer: top level joining front, burst queue and back
// depends on tpm_pkg, tpm_front, tpm_queue, tpm_back
`timescale 1ns / 1ps

// Joins every leftmost non-overlapping "first second" in a word into
// "firstsecond". Load the pattern (left token then right token) with
// action 0 and set both token lengths through the config port between
// words; a length write also empties the match window. The front takes one
// request per cycle and turns it into at most one burst of results; the back
// sends one result per cycle while out_ready is high, one burst at a time.
// A four-entry burst queue sits between them, and the input stalls only
// while that queue is full. Results leave from registers. No clearing pass
// is needed after reset.
module token_pair_merge_replacer import tpm_pkg::*; #(
	parameter int TOKEN_CHARS_MAX = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [ACT_W-1:0]     action,
	input  logic [IDX_W-1:0]     pattern_index,
	input  logic [CHAR_W-1:0]    char_code,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 has_char,
	output logic [CHAR_W-1:0]    out_char,
	output logic                 word_end,
	output logic                 burst_last,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [LEN_W-1:0]     cfg_data
);

	localparam int PAT_DEPTH = 2 * TOKEN_CHARS_MAX;
	localparam int CNT_W     = $clog2(PAT_DEPTH + 1);

	logic                             push;
	logic [PAT_DEPTH-1:0][CHAR_W-1:0] push_chars;
	logic [CNT_W-1:0]                 push_cnt;
	burst_ctl_t                       push_ctl;
	logic                             q_full;
	logic                             q_empty;
	logic                             pop;
	logic [PAT_DEPTH-1:0][CHAR_W-1:0] head_chars;
	logic [CNT_W-1:0]                 head_cnt;
	burst_ctl_t                       head_ctl;

	tpm_front #(
		.TOKEN_CHARS_MAX(TOKEN_CHARS_MAX)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.action        (action),
		.pattern_index (pattern_index),
		.char_code     (char_code),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.q_full        (q_full),
		.push          (push),
		.push_chars    (push_chars),
		.push_cnt      (push_cnt),
		.push_ctl      (push_ctl)
	);

	tpm_queue #(
		.PAT_DEPTH(PAT_DEPTH),
		.CNT_W    (CNT_W)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_chars (push_chars),
		.push_cnt   (push_cnt),
		.push_ctl   (push_ctl),
		.full       (q_full),
		.empty      (q_empty),
		.pop        (pop),
		.head_chars (head_chars),
		.head_cnt   (head_cnt),
		.head_ctl   (head_ctl)
	);

	tpm_back #(
		.PAT_DEPTH(PAT_DEPTH),
		.CNT_W    (CNT_W)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.pop        (pop),
		.head_chars (head_chars),
		.head_cnt   (head_cnt),
		.head_ctl   (head_ctl),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.has_char   (has_char),
		.out_char   (out_char),
		.word_end   (word_end),
		.burst_last (burst_last)
	);

endmodule

FILE: rtl/core/tpm_front.sv
// tpm_front: pattern store, token length registers and match window;
// classifies each request and pushes one burst per result group
// depends on tpm_pkg
`timescale 1ns / 1ps

module tpm_front import tpm_pkg::*; #(
	parameter int TOKEN_CHARS_MAX = 8,
	localparam int PAT_DEPTH = 2 * TOKEN_CHARS_MAX,
	localparam int CNT_W = $clog2(PAT_DEPTH + 1)
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [ACT_W-1:0]                     action,
	input  logic [IDX_W-1:0]                     pattern_index,
	input  logic [CHAR_W-1:0]                    char_code,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [CFG_IDX_W-1:0]                 cfg_index,
	input  logic [LEN_W-1:0]                     cfg_data,
	input  logic                                 q_full,
	output logic                                 push,
	output logic [PAT_DEPTH-1:0][CHAR_W-1:0]     push_chars,
	output logic [CNT_W-1:0]                     push_cnt,
	output burst_ctl_t                           push_ctl
);

	localparam int WIN_DEPTH = PAT_DEPTH + 1;
	localparam int WCNT_W    = $clog2(WIN_DEPTH + 1);

	logic [LEN_W-1:0]                     first_len_q;
	logic [LEN_W-1:0]                     second_len_q;
	logic [WCNT_W-1:0]                    wcnt_q;
	logic [WIN_DEPTH-1:0][CHAR_W-1:0]     win_q;
	logic [PAT_DEPTH-1:0][CHAR_W-1:0]     pat_q;

	logic [WCNT_W-1:0]                    n1;
	logic [WCNT_W-1:0]                    n2;
	logic [WCNT_W-1:0]                    len_w;
	logic [WCNT_W-1:0]                    wcnt_inc;
	logic                                 acc;
	logic                                 full_w;
	logic                                 hit;
	logic                                 push_w;
	logic [WIN_DEPTH-1:0][CHAR_W-1:0]     nw;
	logic [WIN_DEPTH-1:0][CHAR_W-1:0]     nw_shift;
	logic [WIN_DEPTH-1:0][CHAR_W-1:0]     exp_w;
	logic [WIN_DEPTH-1:0]                 mm;
	logic [PAT_DEPTH-1:0][CHAR_W-1:0]     nw_lo;
	logic [PAT_DEPTH-1:0][CHAR_W-1:0]     win_lo;
	logic [PAT_DEPTH-1:0][CHAR_W-1:0]     hit_chars;

	assign cfg_ready = 1'b1;
	assign in_ready  = !q_full;
	assign acc       = in_valid && in_ready;

	// saturate token lengths
	assign n1 = (32'(first_len_q) > TOKEN_CHARS_MAX) ? WCNT_W'(TOKEN_CHARS_MAX)
		: WCNT_W'(first_len_q);
	assign n2 = (32'(second_len_q) > TOKEN_CHARS_MAX) ? WCNT_W'(TOKEN_CHARS_MAX)
		: WCNT_W'(second_len_q);
	assign len_w    = n1 + n2 + WCNT_W'(1);
	assign wcnt_inc = wcnt_q + WCNT_W'(1);
	assign full_w   = (wcnt_inc == len_w);
	assign hit      = full_w && !(|mm);

	for (genvar k = 0; k < WIN_DEPTH; k++) begin : g_win
		assign nw[k] = (wcnt_q == WCNT_W'(k)) ? char_code : win_q[k];
		if (k < WIN_DEPTH - 1) begin : g_sh
			assign nw_shift[k] = nw[k + 1];
		end else begin : g_sh_last
			assign nw_shift[k] = nw[k];
		end
		// expected character: left token, space, right token
		if (k == 0) begin : g_exp0
			assign exp_w[k] = (n1 == WCNT_W'(0)) ? SPACE_CODE : pat_q[k];
		end else if (k < PAT_DEPTH) begin : g_expm
			assign exp_w[k] = (n1 == WCNT_W'(k)) ? SPACE_CODE
				: ((WCNT_W'(k) < n1) ? pat_q[k] : pat_q[k - 1]);
		end else begin : g_expl
			assign exp_w[k] = (n1 == WCNT_W'(k)) ? SPACE_CODE : pat_q[k - 1];
		end
		assign mm[k] = (WCNT_W'(k) < len_w) && (nw[k] != exp_w[k]);
	end

	for (genvar k = 0; k < PAT_DEPTH; k++) begin : g_lo
		assign nw_lo[k]     = nw[k];
		assign win_lo[k]    = win_q[k];
		assign hit_chars[k] = (WCNT_W'(k) < n1) ? nw[k] : nw[k + 1];
	end

	always_comb begin
		push_w     = 1'b0;
		push_cnt   = CNT_W'(1);
		push_ctl   = '{has_char: 1'b1, word_end: 1'b0};
		push_chars = nw_lo;
		unique case (action)
			ACT_CHAR: begin
				if (full_w) begin
					if (hit) begin
						push_w     = (len_w != WCNT_W'(1));
						push_cnt   = CNT_W'(len_w - WCNT_W'(1));
						push_chars = hit_chars;
					end else begin
						push_w = 1'b1;
					end
				end
			end
			ACT_END: begin
				push_w            = 1'b1;
				push_ctl.word_end = 1'b1;
				if (wcnt_q == '0) begin
					push_ctl.has_char = 1'b0;
					push_chars        = '0;
				end else begin
					push_chars = win_lo;
					push_cnt   = CNT_W'(wcnt_q);
				end
			end
			default: ;
		endcase
	end

	assign push = acc && push_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_len_q  <= LEN_W'(1);
			second_len_q <= LEN_W'(1);
			wcnt_q       <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_FIRST_LEN: begin
					first_len_q <= cfg_data;
					wcnt_q      <= '0;
				end
				CFG_SECOND_LEN: begin
					second_len_q <= cfg_data;
					wcnt_q       <= '0;
				end
				default: ;
			endcase
		end else if (acc) begin
			unique case (action)
				ACT_CHAR: begin
					if (full_w) begin
						wcnt_q <= hit ? '0 : wcnt_q;
					end else begin
						wcnt_q <= wcnt_inc;
					end
				end
				ACT_END:  wcnt_q <= '0;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc && action == ACT_CHAR) begin
			win_q <= (full_w && !hit) ? nw_shift : nw;
		end
		if (acc && action == ACT_LOAD) begin
			for (int k = 0; k < PAT_DEPTH; k++) begin
				if (32'(pattern_index) == k) begin
					pat_q[k] <= char_code;
				end
			end
		end
	end

endmodule

FILE: rtl/core/tpm_queue.sv
// tpm_queue: short burst queue between front and back
// depends on tpm_pkg
`timescale 1ns / 1ps

module tpm_queue import tpm_pkg::*; #(
	parameter int PAT_DEPTH = 16,
	parameter int CNT_W = 5
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	input  logic [PAT_DEPTH-1:0][CHAR_W-1:0] push_chars,
	input  logic [CNT_W-1:0]                 push_cnt,
	input  burst_ctl_t                       push_ctl,
	output logic                             full,
	output logic                             empty,
	input  logic                             pop,
	output logic [PAT_DEPTH-1:0][CHAR_W-1:0] head_chars,
	output logic [CNT_W-1:0]                 head_cnt,
	output burst_ctl_t                       head_ctl
);

	logic [PAT_DEPTH-1:0][CHAR_W-1:0] chars_q [QUEUE_DEPTH];
	logic [CNT_W-1:0]                 cnt_mem_q [QUEUE_DEPTH];
	burst_ctl_t                       ctl_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]                wr_ptr_q;
	logic [QPTR_W-1:0]                rd_ptr_q;
	logic [QPTR_W:0]                  cnt_q;

	assign full       = (cnt_q == (QPTR_W + 1)'(QUEUE_DEPTH));
	assign empty      = (cnt_q == '0);
	assign head_chars = chars_q[rd_ptr_q];
	assign head_cnt   = cnt_mem_q[rd_ptr_q];
	assign head_ctl   = ctl_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (QPTR_W + 1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (QPTR_W + 1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			chars_q[wr_ptr_q]   <= push_chars;
			cnt_mem_q[wr_ptr_q] <= push_cnt;
			ctl_q[wr_ptr_q]     <= push_ctl;
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("burst pushed into full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop)
		else $error("burst popped from empty queue");

	a_cnt_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (cnt_q == $past(cnt_q) + (QPTR_W + 1)'(1)))
		else $error("queue fill count did not advance on push");

endmodule

FILE: rtl/core/tpm_back.sv
// tpm_back: drains one burst at a time, one result per cycle while out_ready
// is high, from a registered shift stage; depends on tpm_pkg
`timescale 1ns / 1ps

module tpm_back import tpm_pkg::*; #(
	parameter int PAT_DEPTH = 16,
	parameter int CNT_W = 5
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             q_empty,
	output logic                             pop,
	input  logic [PAT_DEPTH-1:0][CHAR_W-1:0] head_chars,
	input  logic [CNT_W-1:0]                 head_cnt,
	input  burst_ctl_t                       head_ctl,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             has_char,
	output logic [CHAR_W-1:0]                out_char,
	output logic                             word_end,
	output logic                             burst_last
);

	logic                             busy_q;
	logic [CNT_W-1:0]                 rem_q;
	burst_ctl_t                       ctl_q;
	logic [PAT_DEPTH-1:0][CHAR_W-1:0] chars_q;
	logic                             last;

	assign last       = (rem_q == CNT_W'(1));
	assign pop        = !q_empty && (!busy_q || (out_ready && last));
	assign out_valid  = busy_q;
	assign has_char   = ctl_q.has_char;
	assign out_char   = chars_q[0];
	assign word_end   = last && ctl_q.word_end;
	assign burst_last = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rem_q  <= '0;
			ctl_q  <= '0;
		end else if (pop) begin
			busy_q <= 1'b1;
			rem_q  <= head_cnt;
			ctl_q  <= head_ctl;
		end else if (busy_q && out_ready) begin
			if (last) begin
				busy_q <= 1'b0;
			end else begin
				rem_q <= rem_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			chars_q <= head_chars;
		end else if (busy_q && out_ready && !last) begin
			chars_q <= chars_q >> CHAR_W;
		end
	end

	a_busy_rem: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (rem_q != '0))
		else $error("active burst with no results left");

	a_step: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && out_ready && !last) |=>
			(busy_q && rem_q == CNT_W'($past(rem_q) - CNT_W'(1))))
		else $error("burst did not advance by one result");

endmodule

FILE: tb/tb_token_pair_merge_replacer.sv
// tb_token_pair_merge_replacer: self-checking bench for the token pair merge replacer;
// predicts every result from its own copy of the pattern, window and lengths
// depends on tpm_pkg and token_pair_merge_replacer
`timescale 1ns / 1ps

module tb_token_pair_merge_replacer;
	import tpm_pkg::*;

	localparam int TOKEN_MAX     = 8;
	localparam int PAT_DEPTH     = 2 * TOKEN_MAX;
	localparam int WIN_DEPTH     = 2 * TOKEN_MAX + 1;
	localparam int RANDOM_REQS   = 250;
	localparam int SETTLE_CYCLES = 20;
	localparam int DRAIN_LIMIT   = 100000;
	localparam longint CYCLE_LIMIT = 2000000;

	localparam logic [ACT_W-1:0]     ACT_IGNORED = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;
	localparam logic [CHAR_W-1:0]    CODE_MAX    = 21'h10FFFF;
	localparam logic [CHAR_W-1:0]    CODE_A      = 21'h61;
	localparam logic [CHAR_W-1:0]    CODE_B      = 21'h62;
	localparam logic [CHAR_W-1:0]    CODE_C      = 21'h63;

	typedef struct packed {
		logic              has_char;
		logic [CHAR_W-1:0] ch;
		logic              word_end;
		logic              burst_last;
	} rewrite_out_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic [ACT_W-1:0]     action;
	logic [IDX_W-1:0]     pattern_index;
	logic [CHAR_W-1:0]    char_code;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic                 has_char;
	logic [CHAR_W-1:0]    out_char;
	logic                 word_end;
	logic                 burst_last;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [LEN_W-1:0]     cfg_data;

	// predictor state
	logic [CHAR_W-1:0] pat_mem [PAT_DEPTH];
	logic [CHAR_W-1:0] win_buf [WIN_DEPTH];
	int unsigned       win_cnt = 0;
	logic [LEN_W-1:0]  len_first = 4'd1;
	logic [LEN_W-1:0]  len_second = 4'd1;
	rewrite_out_t      rewrite_q [$];

	int unsigned errors = 0;
	int unsigned req_count = 0;
	longint      cycle_count = 0;
	int unsigned ready_hold = 0;
	bit          in_gaps_on = 1'b1;
	bit          out_stalls_on = 1'b1;

	token_pair_merge_replacer #(
		.TOKEN_CHARS_MAX(TOKEN_MAX)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.pattern_index(pattern_index),
		.char_code(char_code),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.has_char(has_char),
		.out_char(out_char),
		.word_end(word_end),
		.burst_last(burst_last),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// receiver stalls: short runs mostly, a few long ones
	always @(posedge clk) begin
		if (ready_hold != 0) begin
			ready_hold <= ready_hold - 1;
		end else if (!out_stalls_on || $urandom_range(0, 2) != 0) begin
			out_ready  <= 1'b1;
			ready_hold <= $urandom_range(0, 6);
		end else begin
			out_ready  <= 1'b0;
			ready_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) :
				$urandom_range(0, 3);
		end
	end

	function automatic int unsigned clamp_tok(input logic [LEN_W-1:0] v);
		return (32'(v) > TOKEN_MAX) ? TOKEN_MAX : 32'(v);
	endfunction

	function automatic void predict_rewrite(input logic [ACT_W-1:0] act,
		input logic [IDX_W-1:0] idx, input logic [CHAR_W-1:0] ch);
		int unsigned  n1, n2, span, k, n;
		bit           hit;
		logic [CHAR_W-1:0] want;
		rewrite_out_t burst [WIN_DEPTH];
		n1   = clamp_tok(len_first);
		n2   = clamp_tok(len_second);
		span = n1 + 1 + n2;
		n    = 0;
		case (act)
			ACT_LOAD: begin
				pat_mem[idx] = ch;
			end
			ACT_CHAR: begin
				if (win_cnt >= WIN_DEPTH)
					win_cnt = 0;
				win_buf[win_cnt] = ch;
				win_cnt++;
				if (win_cnt >= span) begin
					hit = 1'b1;
					for (k = 0; k < span; k++) begin
						if (k == n1)
							want = SPACE_CODE;
						else
							want = pat_mem[(k < n1) ? k : k - 1];
						if (win_buf[k] != want)
							hit = 1'b0;
					end
					if (hit) begin
						for (k = 0; k < span; k++) begin
							if (k != n1) begin
								burst[n] = '{1'b1, win_buf[k], 1'b0, 1'b0};
								n++;
							end
						end
						win_cnt = 0;
					end else begin
						burst[n] = '{1'b1, win_buf[0], 1'b0, 1'b0};
						n++;
						for (k = 0; k + 1 < win_cnt; k++)
							win_buf[k] = win_buf[k + 1];
						win_cnt--;
					end
				end
			end
			ACT_END: begin
				if (win_cnt == 0) begin
					burst[n] = '{1'b0, '0, 1'b1, 1'b0};
					n++;
				end else begin
					for (k = 0; k < win_cnt; k++) begin
						burst[n] = '{1'b1, win_buf[k], 1'b0, 1'b0};
						n++;
					end
					burst[n - 1].word_end = 1'b1;
					win_cnt = 0;
				end
			end
			default: ;
		endcase
		if (n > 0)
			burst[n - 1].burst_last = 1'b1;
		for (k = 0; k < n; k++)
			rewrite_q.push_back(burst[k]);
	endfunction

	function automatic int unsigned idle_gap();
		int unsigned r;
		if (!in_gaps_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [CHAR_W-1:0] pick_alpha();
		case ($urandom_range(0, 4))
			0: return CODE_A;
			1: return CODE_B;
			2: return CODE_C;
			3: return SPACE_CODE;
			default: return '0;
		endcase
	endfunction

	function automatic logic [LEN_W-1:0] pick_len();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r < 7)
			return LEN_W'($urandom_range(0, 3));
		if (r < 9)
			return LEN_W'($urandom_range(4, 8));
		return LEN_W'($urandom_range(9, 15));
	endfunction

	task automatic send_req(input logic [ACT_W-1:0] act, input logic [IDX_W-1:0] idx,
		input logic [CHAR_W-1:0] ch);
		int unsigned gap;
		gap = idle_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid      <= 1'b1;
		action        <= act;
		pattern_index <= idx;
		char_code     <= ch;
		do @(posedge clk); while (!in_ready);
		predict_rewrite(act, idx, ch);
		req_count++;
	endtask

	task automatic send_char(input logic [CHAR_W-1:0] ch);
		send_req(ACT_CHAR, IDX_W'($urandom), ch);
	endtask

	task automatic send_end();
		send_req(ACT_END, IDX_W'($urandom), CHAR_W'($urandom_range(0, CODE_MAX)));
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [LEN_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_FIRST_LEN) begin
			len_first = val;
			win_cnt   = 0;
		end else if (idx == CFG_SECOND_LEN) begin
			len_second = val;
			win_cnt    = 0;
		end
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_lengths(input logic [LEN_W-1:0] a, input logic [LEN_W-1:0] b);
		cfg_write(CFG_FIRST_LEN, a);
		cfg_write(CFG_SECOND_LEN, b);
	endtask

	task automatic wait_drain();
		int unsigned waited;
		waited = 0;
		in_valid <= 1'b0;
		while (rewrite_q.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (rewrite_q.size() != 0) begin
			$error("%0d expected results never arrived", rewrite_q.size());
			errors++;
			rewrite_q.delete();
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// left token, space, right token, as the pattern store holds them now
	task automatic plant_pattern();
		int unsigned n1, n2, k;
		n1 = clamp_tok(len_first);
		n2 = clamp_tok(len_second);
		for (k = 0; k < n1; k++)
			send_char(pat_mem[k]);
		send_char(SPACE_CODE);
		for (k = 0; k < n2; k++)
			send_char(pat_mem[n1 + k]);
	endtask

	task automatic send_word(input int unsigned max_len);
		int unsigned target, sent, r;
		target = $urandom_range(0, max_len);
		sent   = 0;
		while (sent < target) begin
			r = $urandom_range(0, 99);
			if (r < 35) begin
				plant_pattern();
				sent += clamp_tok(len_first) + clamp_tok(len_second) + 1;
			end else begin
				if (r < 39)
					send_req(ACT_LOAD, IDX_W'($urandom), pick_alpha());
				else if (r < 42)
					send_req(ACT_IGNORED, IDX_W'($urandom), CHAR_W'($urandom));
				else if (r < 52)
					send_char(CHAR_W'($urandom_range(0, CODE_MAX)));
				else if (r < 68)
					send_char(SPACE_CODE);
				else
					send_char(pat_mem[$urandom_range(0, PAT_DEPTH - 1)]);
				sent++;
			end
		end
		send_end();
	endtask

	// every slot is written once so no compare ever reads an empty slot
	task automatic test_pattern_load();
		int unsigned k;
		logic [CHAR_W-1:0] v;
		for (k = 0; k < PAT_DEPTH; k++) begin
			case (k)
				0: v = CODE_A;
				1: v = CODE_B;
				2: v = '0;
				3: v = CODE_MAX;
				default: v = CHAR_W'($urandom_range(0, CODE_MAX));
			endcase
			send_req(ACT_LOAD, IDX_W'(k), v);
		end
	endtask

	// reset lengths of one and one: the pattern is "a b"
	task automatic test_basic_words();
		send_end();
		send_char(CODE_A);
		send_char(SPACE_CODE);
		send_char(CODE_B);
		send_end();
		send_char('0);
		send_char(CODE_MAX);
		send_req(ACT_IGNORED, IDX_W'($urandom), CODE_MAX);
		send_char(CODE_A);
		send_end();
		send_char(CODE_C);
		send_char(SPACE_CODE);
		send_char(CODE_A);
		send_char(SPACE_CODE);
		send_char(CODE_B);
		send_char(CODE_B);
		send_end();
		wait_drain();
	endtask

	task automatic test_length_extremes();
		int unsigned firsts [6] = '{0, 8, 15, 0, 8, 3};
		int unsigned seconds [6] = '{0, 8, 15, 8, 0, 11};
		int unsigned k;
		for (k = 0; k < 6; k++) begin
			set_lengths(LEN_W'(firsts[k]), LEN_W'(seconds[k]));
			if (k == 2)
				cfg_write(CFG_SPARE_2, 4'hF);
			if (k == 4)
				cfg_write(CFG_SPARE_3, 4'h0);
			send_char(SPACE_CODE);
			plant_pattern();
			plant_pattern();
			send_end();
			send_word(20);
			wait_drain();
		end
	endtask

	task automatic test_random_stream();
		int unsigned stop_at, phase_end, k;
		stop_at = req_count + RANDOM_REQS;
		while (req_count < stop_at) begin
			in_gaps_on    = ($urandom_range(0, 3) != 0);
			out_stalls_on = ($urandom_range(0, 3) != 0);
			set_lengths(pick_len(), pick_len());
			if ($urandom_range(0, 1) != 0) begin
				for (k = 0; k < PAT_DEPTH; k++)
					send_req(ACT_LOAD, IDX_W'(k), pick_alpha());
			end
			phase_end = req_count + $urandom_range(30, 80);
			while (req_count < phase_end)
				send_word(24);
			wait_drain();
		end
	endtask

	always @(posedge clk) begin : check_results
		rewrite_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (rewrite_q.size() == 0) begin
				$error("result with nothing expected: has_char %0b out_char %h", has_char,
					out_char);
				errors++;
			end else begin
				want = rewrite_q.pop_front();
				if (has_char !== want.has_char) begin
					$error("has_char: expected %0b, got %0b", want.has_char, has_char);
					errors++;
				end
				if (out_char !== want.ch) begin
					$error("out_char: expected %h, got %h", want.ch, out_char);
					errors++;
				end
				if (word_end !== want.word_end) begin
					$error("word_end: expected %0b, got %0b", want.word_end, word_end);
					errors++;
				end
				if (burst_last !== want.burst_last) begin
					$error("burst_last: expected %0b, got %0b", want.burst_last, burst_last);
					errors++;
				end
			end
		end
	end

	initial begin
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		action        = ACT_LOAD;
		pattern_index = '0;
		char_code     = '0;
		cfg_valid     = 1'b0;
		cfg_index     = CFG_FIRST_LEN;
		cfg_data      = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_pattern_load();
		test_basic_words();
		test_length_extremes();
		test_random_stream();
		wait_drain();

		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

FILE: token_pair_merge_replacer.f
rtl/core/tpm_pkg.sv
rtl/core/tpm_front.sv
rtl/core/tpm_queue.sv
rtl/core/tpm_back.sv
rtl/core/token_pair_merge_replacer.sv
tb/tb_token_pair_merge_replacer.sv
